// File: src/gn2d_pkg.sv
// Shared types and constants for the 2D gradient noise evaluator.
package gn2d_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic REG_GRID = 1'b0;
  localparam logic REG_STEP = 1'b1;

  localparam int GRID_CW  = 6;
  localparam int STEP_W   = 24;
  localparam int POINT_W  = 16;
  localparam int CELL_W   = 5;
  localparam int GRAD_W   = 16;
  localparam int NOISE_W  = 16;
  localparam int IN_DW    = 80;

  localparam logic [GRID_CW-1:0] GRID_RST = 6'd32;
  localparam logic [STEP_W-1:0]  STEP_RST = 24'd4096;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // width of a corner dot product in Q.15
  localparam int DOT_W = 19;

  typedef struct packed {
    logic               is_eval;
    logic               wr_ok;
    logic [CELL_W-1:0]  cell_row;
    logic [CELL_W-1:0]  cell_col;
    logic [2*GRAD_W-1:0] grad;     // grad_z high, grad_x low
    logic [POINT_W-1:0] point_row;
    logic [POINT_W-1:0] point_col;
  } gn_item_t;

  typedef struct packed {
    logic     vld;
    gn_item_t item;
  } gn_head_t;

endpackage

// File: src/gn2d_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
module gn2d_front #(
  parameter int GRID_SIZE = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [gn2d_pkg::IN_DW-1:0] in_tdata,
  input  logic                      in_tuser,
  output gn2d_pkg::gn_head_t        head,
  input  logic                      pop
);

  gn2d_pkg::gn_item_t q_r [gn2d_pkg::QDEPTH];
  logic [gn2d_pkg::QAW-1:0] wp_r, rp_r;
  logic [gn2d_pkg::QAW:0]   cnt_r;
  gn2d_pkg::gn_item_t       item;
  logic                     push, do_pop;

  always_comb begin
    item.is_eval   = (in_tuser == gn2d_pkg::OP_EVAL);
    item.cell_row  = in_tdata[4:0];
    item.cell_col  = in_tdata[9:5];
    item.grad      = in_tdata[41:10];
    item.point_row = in_tdata[57:42];
    item.point_col = in_tdata[73:58];
    item.wr_ok     = (int'(in_tdata[4:0]) < GRID_SIZE) && (int'(in_tdata[9:5]) < GRID_SIZE);
  end

  assign in_tready = (cnt_r != (gn2d_pkg::QAW+1)'(gn2d_pkg::QDEPTH));
  assign push      = in_tvalid & in_tready;
  assign do_pop    = pop & (cnt_r != '0);

  assign head.vld  = (cnt_r != '0);
  assign head.item = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (gn2d_pkg::QAW+1)'(push) - (gn2d_pkg::QAW+1)'(do_pop);
    end
  end

endmodule

// File: src/gn2d_gram.sv
// Gradient RAM: one write port, one registered read port.
module gn2d_gram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: src/gn2d_back.sv
// Back end: coordinate, gradient lookup, fade, dot products and interpolation pipeline.
module gn2d_back #(
  parameter int GRID_SIZE = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gn2d_pkg::gn_head_t            head,
  output logic                          pop,
  input  logic [gn2d_pkg::GRID_CW-1:0]  grid_cfg,
  input  logic [gn2d_pkg::STEP_W-1:0]   step_cfg,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [gn2d_pkg::NOISE_W-1:0]  out_tdata
);

  localparam int F   = FRAC_BITS;
  localparam int IW  = $clog2(GRID_SIZE);
  localparam int AW  = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int CW  = gn2d_pkg::POINT_W + gn2d_pkg::STEP_W;
  localparam int XW  = CW - F;
  localparam int PW  = F + 17;
  localparam int DW  = gn2d_pkg::DOT_W;
  localparam int LW  = DW + 2;
  localparam logic [F+4:0] ONE5 = (F+5)'(1) << F;

  logic adv;
  logic out_vld_r;
  logic [gn2d_pkg::NOISE_W-1:0] out_data_r;

  assign adv        = ~out_vld_r | out_tready;
  assign pop        = adv & head.vld;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // grid size in use, clamped to [2, GRID_SIZE]
  logic [8:0]    gv;
  logic [IW-1:0] gm;
  always_comb begin
    priority if (grid_cfg < 6'd2) gv = 9'd2;
    else if (int'(grid_cfg) > GRID_SIZE) gv = 9'(GRID_SIZE);
    else gv = 9'(grid_cfg);
    gm = IW'(gv - 9'd1);
  end

  // stage 1: coordinates
  logic          v1_r, e1_r, w1_r;
  logic [AW-1:0] wa1_r;
  logic [31:0]   wd1_r;
  logic [CW-1:0] c1_r [2];

  // stage 2..9
  logic v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  logic [F-1:0] t_r2 [2], t_r3 [2], t_r4 [2];
  logic [F-1:0] p2_r2 [2];
  logic [F-1:0] p3_r3 [2], p3_r4 [2], p3_r5 [2];
  logic [F-1:0] p4_r4 [2], p4_r5 [2];
  logic [F-1:0] p5_r5 [2];
  logic signed [PW-1:0] mx_r3 [4], mz_r3 [4];
  logic signed [DW-1:0] d_r4 [4], d_r5 [4], d_r6 [4];
  logic [F:0] f_r6 [2];
  logic [F:0] fz_r7, fz_r8;
  logic signed [DW+F+2:0] pa_r7 [2];
  logic signed [DW-1:0]   d0_r7 [2];
  logic signed [LW-1:0]   i_r8 [2];
  logic signed [LW-1:0]   i1_r9;
  logic signed [LW+F+2:0] p3l_r9;

  logic [31:0] q [4];

  // stage 1 combinational: cell, clamp, addresses
  logic [F-1:0]  tx1 [2];
  logic [IW-1:0] lo [2], hi [2];
  logic [AW-1:0] ra [4];
  logic [2*F-1:0] sq [2];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      tx1[a] = c1_r[a][F-1:0];
      lo[a]  = (c1_r[a][CW-1:F] > XW'(gm)) ? gm : IW'(c1_r[a][CW-1:F]);
      hi[a]  = (lo[a] >= gm) ? lo[a] : lo[a] + 1'b1;
      sq[a]  = tx1[a] * tx1[a];
    end
    for (int k = 0; k < 4; k++) begin
      ra[k] = AW'(int'(k[0] ? hi[0] : lo[0]) * GRID_SIZE + int'(k[1] ? hi[1] : lo[1]));
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_ram
    gn2d_gram #(.DEPTH(GRID_SIZE * GRID_SIZE), .AW(AW)) u_ram (
      .clk   (clk),
      .we    (adv & v1_r & ~e1_r & w1_r),
      .waddr (wa1_r),
      .wdata (wd1_r),
      .re    (adv),
      .raddr (ra[k]),
      .rdata (q[k])
    );
  end

  // stage 2 combinational: t^3, gradient products
  logic [2*F-1:0] cu [2];
  logic signed [PW-1:0] mx [4], mz [4];
  logic signed [F:0] dxs, dzs;
  always_comb begin
    for (int a = 0; a < 2; a++) cu[a] = p2_r2[a] * t_r2[a];
    for (int k = 0; k < 4; k++) begin
      dxs   = $signed({k[0], t_r2[0]});
      dzs   = $signed({k[1], t_r2[1]});
      mx[k] = $signed(q[k][15:0]) * dxs;
      mz[k] = $signed(q[k][31:16]) * dzs;
    end
  end

  // stage 3 combinational: t^4, dot sums floored to Q.15
  logic [2*F-1:0] qu [2];
  logic signed [PW:0] sm [4];
  logic signed [DW-1:0] dd [4];
  always_comb begin
    for (int a = 0; a < 2; a++) qu[a] = p3_r3[a] * t_r3[a];
    for (int k = 0; k < 4; k++) begin
      sm[k] = (PW+1)'(mx_r3[k]) + (PW+1)'(mz_r3[k]);
      dd[k] = DW'(sm[k] >>> (F - 1));
    end
  end

  // stage 4 combinational: t^5
  logic [2*F-1:0] qi [2];
  always_comb begin
    for (int a = 0; a < 2; a++) qi[a] = p4_r4[a] * t_r4[a];
  end

  // stage 5 combinational: fade 6t^5 + 10t^3 - 15t^4, clamped to [0, 1]
  logic [F+4:0] fa [2], fb [2], fdf [2];
  logic [F:0]   fv [2];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      fa[a]  = (F+5)'(p5_r5[a]) * (F+5)'(6) + (F+5)'(p3_r5[a]) * (F+5)'(10);
      fb[a]  = (F+5)'(p4_r5[a]) * (F+5)'(15);
      fdf[a] = fa[a] - fb[a];
      priority if (fb[a] > fa[a]) fv[a] = '0;
      else if (fdf[a] > ONE5) fv[a] = (F+1)'(ONE5);
      else fv[a] = fdf[a][F:0];
    end
  end

  // stage 6 combinational: x-direction lerp products
  logic signed [DW:0]     ld [2];
  logic signed [DW+F+2:0] lp [2];
  always_comb begin
    ld[0] = (DW+1)'(d_r6[1]) - (DW+1)'(d_r6[0]);
    ld[1] = (DW+1)'(d_r6[3]) - (DW+1)'(d_r6[2]);
    for (int a = 0; a < 2; a++) lp[a] = ld[a] * $signed({1'b0, f_r6[0]});
  end

  // stage 7 combinational: x-direction lerp sums
  logic signed [LW-1:0] iv [2];
  always_comb begin
    for (int a = 0; a < 2; a++) iv[a] = LW'(d0_r7[a]) + LW'(pa_r7[a] >>> F);
  end

  // stage 8 combinational: z-direction lerp product
  logic signed [LW:0]     zd;
  logic signed [LW+F+2:0] zp;
  always_comb begin
    zd = (LW+1)'(i_r8[1]) - (LW+1)'(i_r8[0]);
    zp = zd * $signed({1'b0, fz_r8});
  end

  // stage 9 combinational: final sum and saturation
  logic signed [LW:0] rv;
  logic [gn2d_pkg::NOISE_W-1:0] rs;
  always_comb begin
    rv = (LW+1)'(i1_r9) + (LW+1)'(p3l_r9 >>> F);
    priority if (rv > 32767) rs = 16'h7fff;
    else if (rv < -32768) rs = 16'h8000;
    else rs = rv[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r  <= head.item.is_eval;
      w1_r  <= head.item.wr_ok;
      wa1_r <= AW'(int'(head.item.cell_row) * GRID_SIZE + int'(head.item.cell_col));
      wd1_r <= head.item.grad;
      c1_r[0] <= CW'(head.item.point_row) * CW'(step_cfg);
      c1_r[1] <= CW'(head.item.point_col) * CW'(step_cfg);
      for (int a = 0; a < 2; a++) begin
        t_r2[a]  <= tx1[a];
        p2_r2[a] <= sq[a][2*F-1:F];
        t_r3[a]  <= t_r2[a];
        p3_r3[a] <= cu[a][2*F-1:F];
        t_r4[a]  <= t_r3[a];
        p3_r4[a] <= p3_r3[a];
        p4_r4[a] <= qu[a][2*F-1:F];
        p3_r5[a] <= p3_r4[a];
        p4_r5[a] <= p4_r4[a];
        p5_r5[a] <= qi[a][2*F-1:F];
        f_r6[a]  <= fv[a];
        pa_r7[a] <= lp[a];
        i_r8[a]  <= iv[a];
      end
      for (int k = 0; k < 4; k++) begin
        mx_r3[k] <= mx[k];
        mz_r3[k] <= mz[k];
        d_r4[k]  <= dd[k];
        d_r5[k]  <= d_r4[k];
        d_r6[k]  <= d_r5[k];
      end
      d0_r7[0] <= d_r6[0];
      d0_r7[1] <= d_r6[2];
      fz_r7    <= f_r6[1];
      fz_r8    <= fz_r7;
      i1_r9    <= i_r8[0];
      p3l_r9   <= zp;
      out_data_r <= rs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      v1_r <= head.vld;
      v2_r <= v1_r & e1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
      out_vld_r <= v9_r;
    end
  end

endmodule

// File: src/gradient_noise_2d_eval.sv
// Top level of the 2D gradient noise evaluator: config registers, front end and back end.
//
// Evaluates 2D gradient noise over a GRID_SIZE x GRID_SIZE table of Q1.14 gradients that
// software loads with write words (tuser 0); an evaluate word (tuser 1) returns one Q1.15
// noise value, a write word returns nothing. Throughput is one word per cycle unless the
// output stalls. The back end is one pipeline that moves as a whole whenever the output
// register is free; the four corner gradients come from four copies of the gradient RAM
// read in the same cycle. A four-word queue sits between input acceptance and the
// pipeline. Gradients must be written before they are read. Change configuration only
// while the block is idle.
module gradient_noise_2d_eval #(
  parameter int GRID_SIZE = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] cell_row, [9:5] cell_col, [25:10] grad_x, [41:26] grad_z,
  // [57:42] point_row, [73:58] point_col, [79:74] zero
  input  logic [79:0] in_tdata,
  // [0] opcode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] noise_value
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  logic [gn2d_pkg::GRID_CW-1:0] grid_r;
  logic [gn2d_pkg::STEP_W-1:0]  step_r;
  gn2d_pkg::gn_head_t           head;
  logic                         pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= gn2d_pkg::GRID_RST;
      step_r <= gn2d_pkg::STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gn2d_pkg::REG_GRID: grid_r <= cfg_data[gn2d_pkg::GRID_CW-1:0];
        gn2d_pkg::REG_STEP: step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gn2d_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head      (head),
    .pop       (pop)
  );

  gn2d_back #(.GRID_SIZE(GRID_SIZE), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .grid_cfg   (grid_r),
    .step_cfg   (step_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
